[rtl/core/conv3x3_image_filter_macros.svh]
// ============================================================================
// Assertion macros for the 3x3 image filter
// Shared concurrent assertion forms, clocked and gated by the active-low reset.
// ============================================================================
`ifndef CONV3X3_IMAGE_FILTER_MACROS_SVH
`define CONV3X3_IMAGE_FILTER_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define CVF_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Condition that must hold in the same cycle as its trigger.
`define CVF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after its trigger.
`define CVF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/cvf_pkg.sv]
// ============================================================================
// Filter package
// Shared codes, configuration and job types of the 3x3 image filter.
// ============================================================================
package cvf_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_FILTER_SELECT = 3'd0;
    localparam logic [2:0] CFG_FRAME_WIDTH   = 3'd1;
    localparam logic [2:0] CFG_FRAME_HEIGHT  = 3'd2;
    localparam logic [2:0] CFG_COLOR_MODE    = 3'd3;
    localparam logic [2:0] CFG_FIRST_ROW     = 3'd4;
    localparam logic [2:0] CFG_END_ROW       = 3'd5;

    // Kernel codes; the two unused codes act as identity.
    localparam logic [2:0] FLT_IDENTITY     = 3'd0;
    localparam logic [2:0] FLT_SMOOTH       = 3'd1;
    localparam logic [2:0] FLT_BLUR         = 3'd2;
    localparam logic [2:0] FLT_SHARPEN      = 3'd3;
    localparam logic [2:0] FLT_MEAN_REMOVAL = 3'd4;
    localparam logic [2:0] FLT_EMBOSS       = 3'd5;

    // Input item kinds.
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    // Job queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int QAW     = $clog2(Q_DEPTH);
    localparam int QLW     = $clog2(Q_DEPTH + 1);

    // Configuration as seen by the datapath, plus a frame restart strobe.
    typedef struct packed {
        logic [2:0]  filter_select;
        logic [11:0] frame_width;
        logic [11:0] frame_height;
        logic        color_mode;
        logic [11:0] first_row;
        logic [11:0] end_row;
        logic        restart;
    } t_cfg;

    // One output pixel to compute: neighborhood, valid taps, row band and frame end flags.
    typedef struct packed {
        logic [2:0][2:0][23:0] win;
        logic [2:0][2:0]       mask;
        logic                  band;
        logic                  last;
    } t_job;

endpackage

[rtl/core/cvf_ifs.sv]
// ============================================================================
// Filter channel interfaces
// Pixel input, result output and configuration write channels.
// ============================================================================

// Pixel or drain item.
interface cvf_pix_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;

    modport source (output valid, action, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, action, in_red, in_green, in_blue, output ready);
endinterface

// Filtered pixel.
interface cvf_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_last;

    modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

// Register write.
interface cvf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [11:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/cvf_queue.sv]
// ============================================================================
// Filter job queue
// Small register FIFO that decouples the window front from the arithmetic back.
// ============================================================================
`include "conv3x3_image_filter_macros.svh"

module cvf_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  cvf_pkg::t_job                i_job,
    input  logic                         i_pop,
    output logic                         o_valid,
    output cvf_pkg::t_job                o_job,
    output logic [cvf_pkg::QLW-1:0]      o_level
);
    import cvf_pkg::*;

    t_job            r_mem [Q_DEPTH];
    logic [QAW-1:0]  r_wr;
    logic [QAW-1:0]  r_rd;
    logic [QLW-1:0]  r_cnt;

    // Pointer and fill count update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QLW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - QLW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign o_level = r_cnt;

    `CVF_ASSERT_IMPLIES(a_q_no_overflow, i_clk, i_rst_n, i_push && !i_pop, 32'(r_cnt) < Q_DEPTH, "job queue overflow")
    `CVF_ASSERT_IMPLIES(a_q_no_underflow, i_clk, i_rst_n, i_pop, r_cnt != '0, "job queue underflow")

endmodule

[rtl/core/cvf_front.sv]
// ============================================================================
// Filter front end
// Accepts pixels and drains, tracks frame position, keeps the line buffers
// and the 3x3 window, and queues one job for every output pixel.
// ============================================================================
`include "conv3x3_image_filter_macros.svh"

module cvf_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  cvf_pkg::t_cfg            i_cfg,
    cvf_pix_if.sink                  i_pix,
    input  logic [cvf_pkg::QLW-1:0]  i_q_level,
    output logic                     o_push,
    output cvf_pkg::t_job            o_job
);
    import cvf_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int DW  = $clog2(MAX_WIDTH + 1);
    localparam int HDW = $clog2(MAX_HEIGHT + 1);
    localparam int HRW = $clog2(MAX_HEIGHT + 2);
    localparam int ORW = $clog2(MAX_HEIGHT);

    logic [DW-1:0]  w_eff;
    logic [HDW-1:0] h_eff;

    // Input position, including the virtual rows past the frame.
    logic [CW-1:0]  r_col, n_col;
    logic [HRW-1:0] r_row, n_row;
    // Position of the next output pixel.
    logic [ORW-1:0] r_orow, n_orow;
    logic [CW-1:0]  r_ocol, n_ocol;

    logic           take, drain, skip, new_frame, go, emit, last, wrap;
    logic [CW-1:0]  cur_col, cur_ocol;
    logic [HRW-1:0] cur_row;
    logic [ORW-1:0] cur_orow;
    logic [2:0]     row_ok, col_ok;
    logic [2:0][2:0] mask;
    logic           band;
    logic [23:0]    pix;

    // Second stage: line buffer read data arrives, window shifts.
    logic            r_b_v;
    logic            r_b_emit;
    logic            r_b_last;
    logic            r_b_band;
    logic [2:0][2:0] r_b_mask;
    logic [23:0]     r_b_pix;
    logic [CW-1:0]   r_b_addr;
    logic            r_fwd_hit;
    logic [47:0]     r_fwd;
    logic [47:0]     r_rd;
    logic [47:0]     b_rd;
    logic [47:0]     b_wdata;

    // Both line buffers share one memory: upper row in the high half.
    logic [47:0]     r_lines [MAX_WIDTH];

    logic [2:0][2:0][23:0] r_win, n_win;

    // Effective frame size: zero means one, oversize means the maximum.
    always_comb begin
        if (i_cfg.frame_width == '0) begin
            w_eff = DW'(1);
        end else if (32'(i_cfg.frame_width) > 32'(MAX_WIDTH)) begin
            w_eff = DW'(MAX_WIDTH);
        end else begin
            w_eff = DW'(i_cfg.frame_width);
        end
        if (i_cfg.frame_height == '0) begin
            h_eff = HDW'(1);
        end else if (32'(i_cfg.frame_height) > 32'(MAX_HEIGHT)) begin
            h_eff = HDW'(MAX_HEIGHT);
        end else begin
            h_eff = HDW'(i_cfg.frame_height);
        end
    end

    // Room in the queue for this item and the one in the second stage.
    assign i_pix.ready = (32'(i_q_level) + 32'(r_b_v)) < Q_DEPTH;
    assign take        = i_pix.valid && i_pix.ready;

    // Classify the item and work out its position and output decision.
    always_comb begin
        drain     = (i_pix.action == ACT_DRAIN);
        skip      = drain && (32'(r_row) < 32'(h_eff));
        new_frame = !drain && (32'(r_row) >= 32'(h_eff));
        go        = take && !skip;

        cur_col  = new_frame ? '0 : r_col;
        cur_row  = new_frame ? '0 : r_row;
        cur_orow = new_frame ? '0 : r_orow;
        cur_ocol = new_frame ? '0 : r_ocol;

        pix = drain ? 24'd0 :
              {i_cfg.color_mode ? i_pix.in_blue : 8'd0,
               i_cfg.color_mode ? i_pix.in_green : 8'd0,
               i_pix.in_red};

        emit = (32'(cur_row) > 32'd1) || ((cur_row == HRW'(1)) && (cur_col != '0));
        last = ((32'(cur_orow) + 32'd1) >= 32'(h_eff)) &&
               ((32'(cur_ocol) + 32'd1) >= 32'(w_eff));
        wrap = (32'(cur_col) + 32'd1) >= 32'(w_eff);

        row_ok[0] = (cur_orow != '0);
        row_ok[1] = 1'b1;
        row_ok[2] = (32'(cur_orow) + 32'd1) < 32'(h_eff);
        col_ok[0] = (cur_ocol != '0);
        col_ok[1] = 1'b1;
        col_ok[2] = (32'(cur_ocol) + 32'd1) < 32'(w_eff);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                mask[r][c] = row_ok[r] && col_ok[c];
            end
        end
        band = (32'(cur_orow) >= 32'(i_cfg.first_row)) &&
               (32'(cur_orow) < 32'(i_cfg.end_row));

        n_col  = wrap ? '0 : cur_col + CW'(1);
        n_row  = wrap ? cur_row + HRW'(1) : cur_row;
        n_orow = cur_orow;
        n_ocol = cur_ocol;
        if (emit && last) begin
            n_col  = '0;
            n_row  = '0;
            n_orow = '0;
            n_ocol = '0;
        end else if (emit) begin
            if ((32'(cur_ocol) + 32'd1) >= 32'(w_eff)) begin
                n_ocol = '0;
                n_orow = cur_orow + ORW'(1);
            end else begin
                n_ocol = cur_ocol + CW'(1);
            end
        end
    end

    // Position counters and second stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_orow    <= '0;
            r_ocol    <= '0;
            r_b_v     <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            if (i_cfg.restart) begin
                r_col  <= '0;
                r_row  <= '0;
                r_orow <= '0;
                r_ocol <= '0;
            end else if (go) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_orow <= n_orow;
                r_ocol <= n_ocol;
            end
            r_b_v     <= go;
            r_fwd_hit <= go && r_b_v && (r_b_addr == cur_col);
        end
    end

    // Second stage payload.
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_b_emit <= emit;
            r_b_last <= last;
            r_b_band <= band;
            r_b_mask <= mask;
            r_b_pix  <= pix;
            r_b_addr <= cur_col;
        end
        r_fwd <= b_wdata;
    end

    // A write in the same cycle as the read of that column is forwarded.
    assign b_rd    = r_fwd_hit ? r_fwd : r_rd;
    assign b_wdata = {b_rd[23:0], r_b_pix};

    // Line buffers: read the column on accept, rotate it in the second stage.
    // Entries are only ever seen by taps that the frame edge masks off before
    // they are written in the current frame, so they need no clearing.
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_rd <= r_lines[cur_col];
        end
        if (r_b_v) begin
            r_lines[r_b_addr] <= b_wdata;
        end
    end

    // Window shift: new column enters on the right.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = b_rd[47:24];
        n_win[1][2] = b_rd[23:0];
        n_win[2][2] = r_b_pix;
    end

    always_ff @(posedge i_clk) begin
        if (r_b_v) begin
            r_win <= n_win;
        end
    end

    assign o_push   = r_b_v && r_b_emit;
    assign o_job    = '{win: n_win, mask: r_b_mask, band: r_b_band, last: r_b_last};

    `CVF_ASSERT_ALWAYS(a_col_in_frame, i_clk, i_rst_n, 32'(r_col) < 32'(w_eff), "input column past frame width")
    `CVF_ASSERT_ALWAYS(a_orow_in_frame, i_clk, i_rst_n, 32'(r_orow) < 32'(h_eff), "output row past frame height")

endmodule

[rtl/core/cvf_back.sv]
// ============================================================================
// Filter back end
// Weights each job's window with the selected kernel, sums, clamps and holds
// the result (the center pixel outside the row band) in the output register.
// ============================================================================
module cvf_back #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cvf_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    input  cvf_pkg::t_job  i_job,
    output logic           o_pop,
    cvf_res_if.source      o_res
);
    import cvf_pkg::*;

    localparam int CFW = COEF_FRAC_BITS + 5;
    localparam int PW  = CFW + 9;
    localparam int SW  = PW + 2;
    localparam int AW  = PW + 4;

    localparam logic signed [CFW-1:0] K_ONE   = CFW'(1 << COEF_FRAC_BITS);
    localparam logic signed [CFW-1:0] K_NINE  = CFW'(9 << COEF_FRAC_BITS);
    localparam logic signed [CFW-1:0] K_NINTH = CFW'(((1 << COEF_FRAC_BITS) * 2 + 9) / 18);
    localparam logic signed [CFW-1:0] K_B1    = CFW'(((1 << COEF_FRAC_BITS) * 2 + 16) / 32);
    localparam logic signed [CFW-1:0] K_B2    = CFW'(((2 << COEF_FRAC_BITS) * 2 + 16) / 32);
    localparam logic signed [CFW-1:0] K_B4    = CFW'(((4 << COEF_FRAC_BITS) * 2 + 16) / 32);
    localparam logic signed [CFW-1:0] K_S2    = CFW'(((2 << COEF_FRAC_BITS) * 2 + 3) / 6);
    localparam logic signed [CFW-1:0] K_S11   = CFW'(((11 << COEF_FRAC_BITS) * 2 + 3) / 6);

    // Weight of window tap (r, c); the kernel is applied flipped.
    function automatic logic signed [CFW-1:0] coef_of(input logic [2:0] sel,
                                                      input int r, input int c);
        logic                  ctr;
        logic                  edg;
        logic signed [CFW-1:0] k;
        ctr = (r == 1) && (c == 1);
        edg = (r == 1) != (c == 1);
        unique case (sel)
            FLT_SMOOTH:       k = K_NINTH;
            FLT_BLUR:         k = ctr ? K_B4 : (edg ? K_B2 : K_B1);
            FLT_SHARPEN:      k = ctr ? K_S11 : (edg ? -K_S2 : '0);
            FLT_MEAN_REMOVAL: k = ctr ? K_NINE : -K_ONE;
            FLT_EMBOSS:       k = (c == 1 && r == 2) ? K_ONE :
                                  ((c == 1 && r == 0) ? -K_ONE : '0);
            default:          k = ctr ? K_ONE : '0;
        endcase
        return k;
    endfunction

    // Drop the fraction and clamp to a byte.
    function automatic logic [7:0] clamp(input logic signed [AW-1:0] a);
        logic [AW-1-COEF_FRAC_BITS:0] q;
        logic [7:0]                   v;
        q = a[AW-1:COEF_FRAC_BITS];
        if (a[AW-1]) begin
            v = 8'd0;
        end else if (|q[AW-1-COEF_FRAC_BITS:8]) begin
            v = 8'd255;
        end else begin
            v = q[7:0];
        end
        return v;
    endfunction

    logic                  s1_adv, s2_adv, o_adv;
    logic signed [PW-1:0]  prod [3][3][3];

    logic                  r_s1_v;
    logic signed [PW-1:0]  r_s1_prod [3][3][3];
    logic                  r_s1_band;
    logic                  r_s1_last;
    logic [23:0]           r_s1_ctr;

    logic                  r_s2_v;
    logic signed [SW-1:0]  r_s2_row [3][3];
    logic                  r_s2_band;
    logic                  r_s2_last;
    logic [23:0]           r_s2_ctr;

    logic signed [AW-1:0]  acc [3];
    logic [7:0]            res [3];

    logic                  r_o_v;
    logic [7:0]            r_o_red, r_o_green, r_o_blue;
    logic                  r_o_last;

    // Stage advance, from the output register backward.
    assign o_adv  = !r_o_v || o_res.ready;
    assign s2_adv = !r_s2_v || o_adv;
    assign s1_adv = !r_s1_v || s2_adv;
    assign o_pop  = i_valid && s1_adv;

    // Tap products per channel; masked taps contribute nothing.
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod[ch][r][c] = i_job.mask[r][c] ?
                        PW'(coef_of(i_cfg.filter_select, r, c)) *
                        PW'($signed({1'b0, i_job.win[r][c][ch*8 +: 8]})) : '0;
                end
            end
        end
    end

    // Row sums and the final total.
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            acc[ch] = AW'(r_s2_row[ch][0]) + AW'(r_s2_row[ch][1]) + AW'(r_s2_row[ch][2]);
            res[ch] = r_s2_band ? clamp(acc[ch]) : r_s2_ctr[ch*8 +: 8];
        end
    end

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_v <= i_valid;
            end
            if (s2_adv) begin
                r_s2_v <= r_s1_v;
            end
            if (o_adv) begin
                r_o_v <= r_s2_v;
            end
        end
    end

    // Product stage.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_prod <= prod;
            r_s1_band <= i_job.band;
            r_s1_last <= i_job.last;
            r_s1_ctr  <= i_job.win[1][1];
        end
    end

    // Row sum stage.
    always_ff @(posedge i_clk) begin
        if (s2_adv && r_s1_v) begin
            for (int ch = 0; ch < 3; ch++) begin
                for (int r = 0; r < 3; r++) begin
                    r_s2_row[ch][r] <= SW'(r_s1_prod[ch][r][0]) + SW'(r_s1_prod[ch][r][1]) +
                                       SW'(r_s1_prod[ch][r][2]);
                end
            end
            r_s2_band <= r_s1_band;
            r_s2_last <= r_s1_last;
            r_s2_ctr  <= r_s1_ctr;
        end
    end

    // Output register; gray mode shows only the first channel.
    always_ff @(posedge i_clk) begin
        if (o_adv && r_s2_v) begin
            r_o_red   <= res[0];
            r_o_green <= i_cfg.color_mode ? res[1] : 8'd0;
            r_o_blue  <= i_cfg.color_mode ? res[2] : 8'd0;
            r_o_last  <= r_s2_last;
        end
    end

    assign o_res.valid      = r_o_v;
    assign o_res.out_red    = r_o_red;
    assign o_res.out_green  = r_o_green;
    assign o_res.out_blue   = r_o_blue;
    assign o_res.frame_last = r_o_last;

endmodule

[rtl/core/conv3x3_image_filter.sv]
// ============================================================================
// 3x3 image filter
// Streaming 3x3 convolution with six fixed kernels, gray or RGB.
// ============================================================================
// Usage:
// Pixels enter in raster order on i_pix with action set to pixel. Each
// output pixel is produced once the pixel one row and one column past it
// has arrived; after a frame's last pixel, drain items (action set to drain)
// push out the pending row and one more pixel, and the final result carries
// frame_last. Drains sent while the frame is still arriving are taken and
// ignored. While i_pix.ready is high the block takes one item per clock, as
// set by the single port pair of the line buffer memory, read on accept and
// written the next cycle. A four-entry job queue and three registered back-end
// stages absorb a stalled receiver; once they fill, i_pix.ready drops until
// o_res transfers again. Registers must be written by the user on i_cfg only
// while no result is pending; nothing in the block enforces this. Writing the
// width or height restarts the frame. Reset restores the register defaults
// and the frame position.
// ============================================================================
module conv3x3_image_filter #(
    parameter int MAX_WIDTH      = 2048,
    parameter int MAX_HEIGHT     = 2048,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cvf_pix_if.sink    i_pix,
    cvf_res_if.source  o_res,
    cvf_cfg_if.sink    i_cfg
);
    import cvf_pkg::*;

    logic [2:0]  r_filter_select;
    logic [11:0] r_frame_width;
    logic [11:0] r_frame_height;
    logic        r_color_mode;
    logic [11:0] r_first_row;
    logic [11:0] r_end_row;

    logic        cfg_wr;
    t_cfg        cfg;
    logic        push, pop, q_valid;
    t_job        push_job, q_job;
    logic [QLW-1:0] q_level;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_select <= FLT_IDENTITY;
            r_frame_width   <= 12'd640;
            r_frame_height  <= 12'd480;
            r_color_mode    <= 1'b0;
            r_first_row     <= 12'd0;
            r_end_row       <= 12'd2048;
        end else if (cfg_wr) begin
            unique case (i_cfg.index)
                CFG_FILTER_SELECT: r_filter_select <= i_cfg.data[2:0];
                CFG_FRAME_WIDTH:   r_frame_width   <= i_cfg.data;
                CFG_FRAME_HEIGHT:  r_frame_height  <= i_cfg.data;
                CFG_COLOR_MODE:    r_color_mode    <= i_cfg.data[0];
                CFG_FIRST_ROW:     r_first_row     <= i_cfg.data;
                CFG_END_ROW:       r_end_row       <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // A new frame size starts a new frame.
    always_comb begin
        cfg.filter_select = r_filter_select;
        cfg.frame_width   = r_frame_width;
        cfg.frame_height  = r_frame_height;
        cfg.color_mode    = r_color_mode;
        cfg.first_row     = r_first_row;
        cfg.end_row       = r_end_row;
        cfg.restart       = cfg_wr && ((i_cfg.index == CFG_FRAME_WIDTH) ||
                                       (i_cfg.index == CFG_FRAME_HEIGHT));
    end

    cvf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_pix     (i_pix),
        .i_q_level (q_level),
        .o_push    (push),
        .o_job     (push_job)
    );

    cvf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_level (q_level)
    );

    cvf_back #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule
